>>> rtl/core/double_ended_message_queue_defines.svh
// Assertion macros for the message queue checker.
`ifndef DOUBLE_ENDED_MESSAGE_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_MESSAGE_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define DMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/dmq_pkg.sv
package dmq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ITEM_BITS   = 32;
    localparam int CFG_BITS    = 5;
    localparam int FUNC_BITS   = 3;
    localparam int SLOT_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int QLEN_RESET  = 16;
    localparam int RESET_LEN   = (QLEN_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH : QLEN_RESET;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_SEND_BACK  = 3'd0,
        FUNC_SEND_FRONT = 3'd1,
        FUNC_OVERWRITE  = 3'd2,
        FUNC_RECEIVE    = 3'd3,
        FUNC_PEEK       = 3'd4,
        FUNC_RESET      = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        logic [ITEM_BITS-1:0] data;
    } t_slot_wr;

    // Length in use: zero acts as one, anything past the built depth clamps.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [CFG_BITS-1:0] q);
        logic [LEN_BITS-1:0] len;
        if (q == '0) begin
            len = LEN_BITS'(1);
        end else if (32'(q) > 32'(QUEUE_DEPTH)) begin
            len = LEN_BITS'(QUEUE_DEPTH);
        end else begin
            len = LEN_BITS'(q);
        end
        return len;
    endfunction

endpackage

>>> rtl/core/dmq_slots.sv
module dmq_slots #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-before-write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/double_ended_message_queue.sv
// A transaction accepted on start passes the input register, then the result
//   register, before its result shows with o_done.
// Throughput: one transaction per cycle, no stall; busy is high only in reset.
// Reset (synchronous, i_rst_n low): ring empty, length 16, write slot 0,
//   read slot at length minus one; slot contents are left as they were.
// The receiver cannot stall: each result shows for exactly one cycle.
module double_ended_message_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [dmq_pkg::FUNC_BITS-1:0]    i_func,
    input  logic [dmq_pkg::ITEM_BITS-1:0]    i_data_in,
    // length register
    input  logic                             i_cfg_we,
    input  logic [dmq_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    // result channel
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [dmq_pkg::ITEM_BITS-1:0]    o_read_data,
    output logic [dmq_pkg::LEN_BITS-1:0]     o_message_count,
    output logic [dmq_pkg::LEN_BITS-1:0]     o_free_space,
    output logic                             o_is_empty,
    output logic                             o_is_full
);
    import dmq_pkg::*;

    // input register
    logic                   r_in_valid;
    logic [FUNC_BITS-1:0]   r_func;
    logic [ITEM_BITS-1:0]   r_data;

    // ring state
    logic [CFG_BITS-1:0]    r_qlen;
    logic [SLOT_BITS-1:0]   r_write_slot, n_write_slot;
    logic [SLOT_BITS-1:0]   r_read_slot,  n_read_slot;
    logic [LEN_BITS-1:0]    r_count,      n_count;

    // result register
    logic                   r_done;
    t_status                r_status,     n_status;
    logic [ITEM_BITS-1:0]   r_read_data,  n_read_data;
    logic [LEN_BITS-1:0]    r_msg_count;
    logic [LEN_BITS-1:0]    r_free,       n_free;
    logic                   r_empty,      n_empty;
    logic                   r_full,       n_full;

    logic [LEN_BITS-1:0]    len;
    logic                   ring_full;
    logic                   ring_empty;
    logic [LEN_BITS-1:0]    rd_inc;
    logic [LEN_BITS-1:0]    wr_inc;
    logic [SLOT_BITS-1:0]   rd_next;
    logic [SLOT_BITS-1:0]   rd_prev;
    logic [SLOT_BITS-1:0]   wr_next;
    logic [ITEM_BITS-1:0]   slot_rd_data;
    t_slot_wr               slot_wr;

    // slot read issued at the edge that loads the transaction into the input register
    logic [SLOT_BITS-1:0]   rd_base;
    logic [LEN_BITS-1:0]    rd_base_inc;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [ITEM_BITS-1:0]   ram_rd_data;
    logic                   r_byp_hit;
    logic [ITEM_BITS-1:0]   r_byp_data;

    logic                   accept;

    // Nothing ever holds off a command except reset itself.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_data <= i_data_in;
        end
    end

    // Wrap arithmetic inside the configured length.
    assign len        = eff_len(r_qlen);
    assign ring_full  = (r_count >= len);
    assign ring_empty = (r_count == '0);
    assign rd_inc     = LEN_BITS'(r_read_slot) + LEN_BITS'(1);
    assign wr_inc     = LEN_BITS'(r_write_slot) + LEN_BITS'(1);
    assign rd_next    = (rd_inc >= len) ? '0 : SLOT_BITS'(rd_inc);
    assign wr_next    = (wr_inc >= len) ? '0 : SLOT_BITS'(wr_inc);
    assign rd_prev    = (r_read_slot == '0) ? SLOT_BITS'(len - LEN_BITS'(1))
                                            : r_read_slot - SLOT_BITS'(1);

    // Receive and peek both look at the slot just past the read slot. The
    // RAM read is registered, so the address is taken from the read slot as
    // it will stand after this edge: the transaction accepted now finds its
    // word on the RAM output while it sits in the input register. A length
    // write parks the read slot at length minus one, so the slot after is 0.
    assign rd_base     = r_in_valid ? n_read_slot : r_read_slot;
    assign rd_base_inc = LEN_BITS'(rd_base) + LEN_BITS'(1);
    assign rd_addr     = (i_cfg_we || rd_base_inc >= len) ? '0 : SLOT_BITS'(rd_base_inc);

    dmq_slots #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_wr.en),
        .i_waddr (slot_wr.addr),
        .i_wdata (slot_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (ram_rd_data)
    );

    // A write landing on the slot being read at the same edge is not yet
    // in the RAM output; forward the written word instead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= slot_wr.en && (slot_wr.addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= slot_wr.data;
    end

    assign slot_rd_data = r_byp_hit ? r_byp_data : ram_rd_data;

    always_comb begin
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_count      = r_count;
        n_status     = ST_OK;
        n_read_data  = '0;
        slot_wr.en   = 1'b0;
        slot_wr.addr = r_write_slot;
        slot_wr.data = r_data;

        case (t_func'(r_func))
            FUNC_SEND_BACK: begin
                if (ring_full) begin
                    n_status = ST_FULL;
                end else begin
                    slot_wr.en   = r_in_valid;
                    n_write_slot = wr_next;
                    n_count      = r_count + LEN_BITS'(1);
                end
            end
            FUNC_SEND_FRONT, FUNC_OVERWRITE: begin
                if (ring_full) begin
                    n_status = ST_FULL;
                end else begin
                    slot_wr.en   = r_in_valid;
                    slot_wr.addr = r_read_slot;
                    n_read_slot  = rd_prev;
                    // overwrite keeps the count unless the ring was empty
                    if (!(t_func'(r_func) == FUNC_OVERWRITE && !ring_empty)) begin
                        n_count = r_count + LEN_BITS'(1);
                    end
                end
            end
            FUNC_RECEIVE, FUNC_PEEK: begin
                if (ring_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_data = slot_rd_data;
                    if (t_func'(r_func) == FUNC_RECEIVE) begin
                        n_read_slot = rd_next;
                        n_count     = r_count - LEN_BITS'(1);
                    end
                end
            end
            FUNC_RESET: begin
                n_write_slot = '0;
                n_read_slot  = SLOT_BITS'(len - LEN_BITS'(1));
                n_count      = '0;
            end
            default: begin
                // unused codes: no change, plain success
            end
        endcase

        n_free  = len - n_count;
        n_empty = (n_count == '0);
        n_full  = (n_count == len);
    end

    // State. A length write empties the ring for the new length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen       <= CFG_BITS'(QLEN_RESET);
            r_write_slot <= '0;
            r_read_slot  <= SLOT_BITS'(RESET_LEN - 1);
            r_count      <= '0;
        end else if (i_cfg_we) begin
            r_qlen       <= i_cfg_wdata;
            r_write_slot <= '0;
            r_read_slot  <= SLOT_BITS'(eff_len(i_cfg_wdata) - LEN_BITS'(1));
            r_count      <= '0;
        end else if (r_in_valid) begin
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_count      <= n_count;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    // Result payload, loaded with each transaction
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_status    <= n_status;
            r_read_data <= n_read_data;
            r_msg_count <= n_count;
            r_free      <= n_free;
            r_empty     <= n_empty;
            r_full      <= n_full;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_data     = r_read_data;
    assign o_message_count = r_msg_count;
    assign o_free_space    = r_free;
    assign o_is_empty      = r_empty;
    assign o_is_full       = r_full;

endmodule

>>> rtl/core/dmq_checker.sv
`include "double_ended_message_queue_defines.svh"

module dmq_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             o_done,
    input  logic [1:0]                       o_status,
    input  logic [dmq_pkg::ITEM_BITS-1:0]    o_read_data,
    input  logic [dmq_pkg::LEN_BITS-1:0]     o_message_count,
    input  logic [dmq_pkg::LEN_BITS-1:0]     o_free_space,
    input  logic                             o_is_empty,
    input  logic                             o_is_full
);
    import dmq_pkg::*;

    logic accept;
    logic [LEN_BITS:0] used_plus_free;
    logic empty_seen;
    logic full_seen;
    logic empty_ok;
    logic full_ok;
    logic counts_ok;

    assign accept         = start && !busy;
    assign used_plus_free = {1'b0, o_message_count} + {1'b0, o_free_space};
    assign empty_seen     = o_done && (o_status == ST_EMPTY);
    assign full_seen      = o_done && (o_status == ST_FULL);
    assign empty_ok       = o_is_empty && (o_read_data == '0);
    assign full_ok        = o_is_full && (o_free_space == '0);
    assign counts_ok      = (o_is_empty == (o_message_count == '0))
                            && (32'(used_plus_free) <= 32'(QUEUE_DEPTH));

    // every accepted transaction answers with o_done after the input and result registers
    `DMQ_ASSERT_NEXT(a_latency, accept, ##1 o_done, "transaction result missing")

    // empty status comes with an empty ring and no data
    `DMQ_ASSERT_NOW(a_empty_status, empty_seen, empty_ok, "empty status inconsistent")

    // full status only when the ring is full and has no room
    `DMQ_ASSERT_NOW(a_full_status, full_seen, full_ok, "full status inconsistent")

    // flags and counts agree, never more than the built depth
    `DMQ_ASSERT_NOW(a_counts, o_done, counts_ok, "count flags inconsistent")

endmodule

bind double_ended_message_queue dmq_checker u_dmq_checker (.*);
